// ===== sv/h2r_pkg.sv =====
// Shared types, constants and helper functions for the HSV to RGB converter.
// No dependencies; every other file imports this package.
package h2r_pkg;

    localparam int             PIPE_LATENCY = 7;

    localparam logic [8:0]     ONE_Q8       = 9'd256;
    localparam logic [8:0]     HUE_MOD      = 9'd360;
    localparam logic [8:0]     SECTOR_DEG   = 9'd60;
    localparam logic [7:0]     ALPHA        = 8'hFF;

    localparam logic [15:0]    HUE_RECIP    = 16'd46603;
    localparam int             HUE_SHIFT    = 24;
    localparam logic [18:0]    FRAC_RECIP   = 19'd279680;
    localparam int             FRAC_SHIFT   = 16;

    localparam logic [2:0]     SEC_R_TO_Y   = 3'd0;
    localparam logic [2:0]     SEC_Y_TO_G   = 3'd1;
    localparam logic [2:0]     SEC_G_TO_C   = 3'd2;
    localparam logic [2:0]     SEC_C_TO_B   = 3'd3;
    localparam logic [2:0]     SEC_B_TO_M   = 3'd4;
    localparam logic [2:0]     SEC_M_TO_R   = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [15:0] hue;
        logic [9:0]  sat;
        logic [9:0]  bri;
    } t_hsv_req;

    typedef struct packed {
        logic       valid;
        logic [2:0] sector;
        logic [7:0] frac;
        logic [8:0] sat;
        logic [8:0] bri;
    } t_sector_req;

    typedef struct packed {
        logic       valid;
        logic [2:0] sector;
        logic [8:0] v;
        logic [8:0] p;
        logic [8:0] q;
        logic [8:0] t;
    } t_shade_req;

    function automatic logic [8:0] clamp_q8(input logic [9:0] raw);
        logic [8:0] res;
        if (raw[9]) begin
            res = '0;
        end else if (raw[8:0] > ONE_Q8) begin
            res = ONE_Q8;
        end else begin
            res = raw[8:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] to_byte(input logic [8:0] x);
        logic [8:0] dec;
        dec = x - 9'd1;
        return (x == '0) ? 8'd0 : dec[7:0];
    endfunction

endpackage

// ===== sv/h2r_hue_reduce.sv =====
// Hue front end: clamps saturation and value, reduces hue modulo 360,
// splits it into sector and Q0.8 fraction over four register stages. Uses h2r_pkg.
module h2r_hue_reduce
    import h2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_hsv_req    i_req,
    output t_sector_req o_req
);

    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [15:0] r_s1_hue;
    logic [7:0]  r_s1_quot;
    logic [8:0]  r_s1_sat, r_s2_sat, r_s3_sat, r_s4_sat;
    logic [8:0]  r_s1_bri, r_s2_bri, r_s3_bri, r_s4_bri;
    logic [8:0]  r_s2_hmod;
    logic [2:0]  r_s3_sector, r_s4_sector;
    logic [5:0]  r_s3_rem;
    logic [7:0]  r_s4_frac;

    logic [31:0] w_hue_prod;
    logic [16:0] w_base;
    logic [16:0] w_diff;
    logic [9:0]  w_hmod_raw;
    logic [8:0]  n_hmod;
    logic [2:0]  n_sector;
    logic [8:0]  w_sec_base;
    logic [8:0]  w_rem;
    logic [24:0] w_frac_prod;

    assign w_hue_prod = 32'(i_req.hue) * 32'(HUE_RECIP);

    assign w_base     = 17'(r_s1_quot) * 17'(HUE_MOD);
    assign w_diff     = 17'(r_s1_hue) - w_base;
    assign w_hmod_raw = w_diff[9:0];

    always_comb begin
        if (w_hmod_raw >= 10'(HUE_MOD)) begin
            n_hmod = 9'(w_hmod_raw - 10'(HUE_MOD));
        end else begin
            n_hmod = w_hmod_raw[8:0];
        end
    end

    always_comb begin
        if (r_s2_hmod < SECTOR_DEG) begin
            n_sector   = SEC_R_TO_Y;
            w_sec_base = 9'd0;
        end else if (r_s2_hmod < 9'(2 * SECTOR_DEG)) begin
            n_sector   = SEC_Y_TO_G;
            w_sec_base = SECTOR_DEG;
        end else if (r_s2_hmod < 9'(3 * SECTOR_DEG)) begin
            n_sector   = SEC_G_TO_C;
            w_sec_base = 9'(2 * SECTOR_DEG);
        end else if (r_s2_hmod < 9'(4 * SECTOR_DEG)) begin
            n_sector   = SEC_C_TO_B;
            w_sec_base = 9'(3 * SECTOR_DEG);
        end else if (r_s2_hmod < 9'(5 * SECTOR_DEG)) begin
            n_sector   = SEC_B_TO_M;
            w_sec_base = 9'(4 * SECTOR_DEG);
        end else begin
            n_sector   = SEC_M_TO_R;
            w_sec_base = 9'(5 * SECTOR_DEG);
        end
    end

    assign w_rem       = r_s2_hmod - w_sec_base;
    assign w_frac_prod = 25'(r_s3_rem) * 25'(FRAC_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hue    <= i_req.hue;
        r_s1_quot   <= w_hue_prod[HUE_SHIFT +: 8];
        r_s1_sat    <= clamp_q8(i_req.sat);
        r_s1_bri    <= clamp_q8(i_req.bri);

        r_s2_hmod   <= n_hmod;
        r_s2_sat    <= r_s1_sat;
        r_s2_bri    <= r_s1_bri;

        r_s3_sector <= n_sector;
        r_s3_rem    <= w_rem[5:0];
        r_s3_sat    <= r_s2_sat;
        r_s3_bri    <= r_s2_bri;

        r_s4_sector <= r_s3_sector;
        r_s4_frac   <= w_frac_prod[FRAC_SHIFT +: 8];
        r_s4_sat    <= r_s3_sat;
        r_s4_bri    <= r_s3_bri;
    end

    assign o_req.valid  = r_s4_valid;
    assign o_req.sector = r_s4_sector;
    assign o_req.frac   = r_s4_frac;
    assign o_req.sat    = r_s4_sat;
    assign o_req.bri    = r_s4_bri;

endmodule

// ===== sv/h2r_shade.sv =====
// Shade products: builds p, q and t from value, saturation and fraction
// over two register stages. Uses h2r_pkg.
module h2r_shade
    import h2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sector_req i_req,
    output t_shade_req  o_req
);

    logic       r_a_valid, r_b_valid;
    logic [2:0] r_a_sector, r_b_sector;
    logic [8:0] r_a_v, r_b_v;
    logic [8:0] r_a_p, r_b_p;
    logic [8:0] r_a_sf, r_a_sg;
    logic [8:0] r_b_q, r_b_t;

    logic [8:0]  w_inv_frac;
    logic [8:0]  w_inv_sat;
    logic [16:0] w_sf_prod, w_sg_prod, w_p_prod;
    logic [8:0]  w_inv_sf, w_inv_sg;
    logic [16:0] w_q_prod, w_t_prod;

    assign w_inv_frac = ONE_Q8 - 9'(i_req.frac);
    assign w_inv_sat  = ONE_Q8 - i_req.sat;
    assign w_sf_prod  = 17'(i_req.sat) * 17'(i_req.frac);
    assign w_sg_prod  = 17'(i_req.sat) * 17'(w_inv_frac);
    assign w_p_prod   = 17'(i_req.bri) * 17'(w_inv_sat);

    assign w_inv_sf   = ONE_Q8 - r_a_sf;
    assign w_inv_sg   = ONE_Q8 - r_a_sg;
    assign w_q_prod   = 17'(r_a_v) * 17'(w_inv_sf);
    assign w_t_prod   = 17'(r_a_v) * 17'(w_inv_sg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_req.valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sector <= i_req.sector;
        r_a_v      <= i_req.bri;
        r_a_p      <= w_p_prod[16:8];
        r_a_sf     <= w_sf_prod[16:8];
        r_a_sg     <= w_sg_prod[16:8];

        r_b_sector <= r_a_sector;
        r_b_v      <= r_a_v;
        r_b_p      <= r_a_p;
        r_b_q      <= w_q_prod[16:8];
        r_b_t      <= w_t_prod[16:8];
    end

    assign o_req.valid  = r_b_valid;
    assign o_req.sector = r_b_sector;
    assign o_req.v      = r_b_v;
    assign o_req.p      = r_b_p;
    assign o_req.q      = r_b_q;
    assign o_req.t      = r_b_t;

endmodule

// ===== sv/h2r_pack.sv =====
// Output stage: routes v, p, q, t to red, green and blue by sector, scales
// each to a byte and registers the packed ARGB word. Uses h2r_pkg.
module h2r_pack
    import h2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_shade_req  i_req,
    output logic        o_valid,
    output logic [31:0] o_argb
);

    logic        r_valid;
    logic [31:0] r_argb;
    logic [8:0]  w_red, w_green, w_blue;

    always_comb begin
        unique case (i_req.sector)
            SEC_R_TO_Y: begin
                w_red = i_req.v; w_green = i_req.t; w_blue = i_req.p;
            end
            SEC_Y_TO_G: begin
                w_red = i_req.q; w_green = i_req.v; w_blue = i_req.p;
            end
            SEC_G_TO_C: begin
                w_red = i_req.p; w_green = i_req.v; w_blue = i_req.t;
            end
            SEC_C_TO_B: begin
                w_red = i_req.p; w_green = i_req.q; w_blue = i_req.v;
            end
            SEC_B_TO_M: begin
                w_red = i_req.t; w_green = i_req.p; w_blue = i_req.v;
            end
            default: begin
                w_red = i_req.v; w_green = i_req.p; w_blue = i_req.q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_argb <= {ALPHA, to_byte(w_red), to_byte(w_green), to_byte(w_blue)};
    end

    assign o_valid = r_valid;
    assign o_argb  = r_argb;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// HSV to ARGB converter, top level. Uses h2r_pkg, h2r_hue_reduce, h2r_shade, h2r_pack.
// A request passes the hue stages s1 to s4, the shade stages a and b and the pack register before its result.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// The rate is set by the fully pipelined seven-stage datapath, each stage new every cycle.
// Synchronous active-low reset clears all pipeline valid bits; data is not reset.
module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_hue,
    input  logic [9:0]  i_saturation,
    input  logic [9:0]  i_brightness,
    output logic        o_valid,
    output logic [31:0] o_argb
);

    t_hsv_req    w_hsv_req;
    t_sector_req w_sector_req;
    t_shade_req  w_shade_req;

    assign busy = 1'b0;

    assign w_hsv_req.valid = start && !busy;
    assign w_hsv_req.hue   = i_hue;
    assign w_hsv_req.sat   = i_saturation;
    assign w_hsv_req.bri   = i_brightness;

    h2r_hue_reduce u_hue_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_hsv_req),
        .o_req   (w_sector_req)
    );

    h2r_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sector_req),
        .o_req   (w_shade_req)
    );

    h2r_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_shade_req),
        .o_valid (o_valid),
        .o_argb  (o_argb)
    );

endmodule

// ===== sv/h2r_checker.sv =====
// Port-level checker for hsv_to_rgb_converter and the bind that attaches it.
// Depends on h2r_pkg and the top level's ports.
module h2r_checker
    import h2r_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] i_hue,
    input logic [9:0]  i_saturation,
    input logic [9:0]  i_brightness,
    input logic        o_valid,
    input logic [31:0] o_argb
);

    a_req_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("accepted request produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##7 !o_valid)
        else $error("result without a request");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_gray_on_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_saturation[9] || i_saturation == 10'd0)) |-> ##7
        (o_argb[31:24] == ALPHA && o_argb[23:16] == o_argb[15:8]
            && o_argb[15:8] == o_argb[7:0]))
        else $error("zero saturation did not give gray");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_hue        (i_hue),
    .i_saturation (i_saturation),
    .i_brightness (i_brightness),
    .o_valid      (o_valid),
    .o_argb       (o_argb)
);
